// ===== rtl/core/cnlc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cnlc_pkg: shared widths and codes of the card number Luhn classifier
// Field widths, decimal digit counts and the class codes that are used by
// the classifier core and by its port checker.
// ----------------------------------------------------------------------------
package cnlc_pkg;

	// Field widths.
	localparam int VALUE_W   = 63;
	localparam int VERDICT_W = 2;
	localparam int COUNT_W   = 5;

	// Decimal digits needed for the largest card value, and the BCD word.
	localparam int NUM_DIGITS = 19;
	localparam int BCD_W      = 4 * NUM_DIGITS;

	// Counter widths for the conversion and scan phases.
	localparam int BIT_CNT_W = $clog2(VALUE_W);
	localparam int DIG_CNT_W = $clog2(NUM_DIGITS);

	typedef logic [3:0]           bcd_digit_t;
	typedef logic [VERDICT_W-1:0] verdict_t;
	typedef logic [COUNT_W-1:0]   count_t;

	// Class codes.
	localparam verdict_t VERDICT_INVALID      = 2'd0;
	localparam verdict_t VERDICT_PREFIX_34_37 = 2'd1;
	localparam verdict_t VERDICT_PREFIX_51_55 = 2'd2;
	localparam verdict_t VERDICT_LEAD_4       = 2'd3;

	// Accepted lengths.
	localparam count_t LEN_13 = 5'd13;
	localparam count_t LEN_15 = 5'd15;
	localparam count_t LEN_16 = 5'd16;

endpackage

// ===== rtl/core/card_number_luhn_classifier.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// card_number_luhn_classifier: Luhn mod-10 check and prefix class of a card
// Converts a binary card number to decimal one bit per cycle, then walks the
// decimal digits one per cycle to count them, run the Luhn sum and pick out
// the two leading digits, and finally reports the class.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Transfer rule               Payload
// -------   ---------  --------------------------  ------------------------------
// command   in         start && !busy at clk edge  card_value
// result    out        done high for one cycle     verdict, digit_count, checksum_ok
//
// Each item runs through bit-serial binary to BCD conversion (one input bit per
// cycle), then the digit scan (one decimal digit per cycle), then a final state
// that forms the class. busy is high through all of that; the next start is
// taken in the cycle in which done is shown. arst_n clears the control state.
// The receiver cannot stall: done marks each result for exactly one cycle.
//
module card_number_luhn_classifier (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic [cnlc_pkg::VALUE_W-1:0]   card_value,
	output logic                           done,
	output logic [cnlc_pkg::VERDICT_W-1:0] verdict,
	output logic [cnlc_pkg::COUNT_W-1:0]   digit_count,
	output logic                           checksum_ok
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_CONV = 2'd1;
	localparam logic [1:0] ST_SCAN = 2'd2;
	localparam logic [1:0] ST_FIN  = 2'd3;

	localparam logic [cnlc_pkg::BIT_CNT_W-1:0] BIT_LAST =
		cnlc_pkg::BIT_CNT_W'(cnlc_pkg::VALUE_W - 1);
	localparam logic [cnlc_pkg::DIG_CNT_W-1:0] DIG_LAST =
		cnlc_pkg::DIG_CNT_W'(cnlc_pkg::NUM_DIGITS - 1);

	logic [1:0]                         state_q;
	logic [cnlc_pkg::VALUE_W-1:0]       bin_q;
	logic [cnlc_pkg::BCD_W-1:0]         bcd_q;
	logic [cnlc_pkg::BCD_W-1:0]         bcd_adj;
	logic [cnlc_pkg::BIT_CNT_W-1:0]     bit_cnt_q;
	logic [cnlc_pkg::DIG_CNT_W-1:0]     dig_cnt_q;
	logic [3:0]                         sum_q;
	logic [4:0]                         sum_next;
	logic [3:0]                         luhn_add;
	logic [4:0]                         dbl;
	cnlc_pkg::bcd_digit_t               cur_digit;
	cnlc_pkg::bcd_digit_t               prev_q;
	cnlc_pkg::bcd_digit_t               lead_hi_q;
	cnlc_pkg::bcd_digit_t               lead_lo_q;
	cnlc_pkg::count_t                   len_q;
	cnlc_pkg::verdict_t                 verdict_next;
	logic                               len_ok;
	logic                               done_q;
	cnlc_pkg::verdict_t                 verdict_q;
	cnlc_pkg::count_t                   digit_count_q;
	logic                               checksum_ok_q;

	// Double-dabble adjust: every BCD digit of five or more gets three added
	// before the shift.
	always_comb begin
		for (int i = 0; i < cnlc_pkg::NUM_DIGITS; i++) begin
			if (bcd_q[4*i +: 4] >= 4'd5) begin
				bcd_adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
			end else begin
				bcd_adj[4*i +: 4] = bcd_q[4*i +: 4];
			end
		end
	end

	// Luhn contribution of the digit under scan; odd positions are doubled.
	assign cur_digit = bcd_q[3:0];
	assign dbl       = {cur_digit, 1'b0};

	always_comb begin
		if (!dig_cnt_q[0]) begin
			luhn_add = cur_digit;
		end else if (dbl > 5'd9) begin
			luhn_add = 4'(dbl - 5'd9);
		end else begin
			luhn_add = dbl[3:0];
		end
	end

	// The running sum is kept modulo ten.
	always_comb begin
		sum_next = {1'b0, sum_q} + {1'b0, luhn_add};
		if (sum_next >= 5'd10) begin
			sum_next = sum_next - 5'd10;
		end
	end

	// Class from the length, the check and the two leading digits.
	always_comb begin
		len_ok       = len_q inside {cnlc_pkg::LEN_13, cnlc_pkg::LEN_15, cnlc_pkg::LEN_16};
		verdict_next = cnlc_pkg::VERDICT_INVALID;
		if (len_ok && (sum_q == 4'd0)) begin
			if (lead_hi_q == 4'd3 && (lead_lo_q == 4'd4 || lead_lo_q == 4'd7)) begin
				verdict_next = cnlc_pkg::VERDICT_PREFIX_34_37;
			end else if (lead_hi_q == 4'd5 && lead_lo_q inside {[4'd1:4'd5]}) begin
				verdict_next = cnlc_pkg::VERDICT_PREFIX_51_55;
			end else if (lead_hi_q == 4'd4) begin
				verdict_next = cnlc_pkg::VERDICT_LEAD_4;
			end
		end
	end

	// Sequencer and result strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			bit_cnt_q <= '0;
			dig_cnt_q <= '0;
			done_q    <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q   <= ST_CONV;
						bit_cnt_q <= '0;
					end
				end
				ST_CONV: begin
					bit_cnt_q <= bit_cnt_q + 1'b1;
					if (bit_cnt_q == BIT_LAST) begin
						state_q   <= ST_SCAN;
						dig_cnt_q <= '0;
					end
				end
				ST_SCAN: begin
					dig_cnt_q <= dig_cnt_q + 1'b1;
					if (dig_cnt_q == DIG_LAST) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					state_q <= ST_IDLE;
					done_q  <= 1'b1;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Datapath: conversion shift registers, digit scan and result registers.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				bin_q     <= card_value;
				bcd_q     <= '0;
				sum_q     <= '0;
				prev_q    <= '0;
				lead_hi_q <= '0;
				lead_lo_q <= '0;
				len_q     <= '0;
			end
			ST_CONV: begin
				bcd_q <= {bcd_adj[cnlc_pkg::BCD_W-2:0], bin_q[cnlc_pkg::VALUE_W-1]};
				bin_q <= {bin_q[cnlc_pkg::VALUE_W-2:0], 1'b0};
			end
			ST_SCAN: begin
				bcd_q  <= {4'd0, bcd_q[cnlc_pkg::BCD_W-1:4]};
				sum_q  <= sum_next[3:0];
				prev_q <= cur_digit;
				if (cur_digit != 4'd0) begin
					len_q     <= cnlc_pkg::COUNT_W'(dig_cnt_q) + 1'b1;
					lead_hi_q <= cur_digit;
					lead_lo_q <= prev_q;
				end
			end
			ST_FIN: begin
				verdict_q     <= verdict_next;
				digit_count_q <= len_q;
				checksum_ok_q <= (sum_q == 4'd0);
			end
			default: begin
				bcd_q <= bcd_q;
			end
		endcase
	end

	assign busy        = (state_q != ST_IDLE);
	assign done        = done_q;
	assign verdict     = verdict_q;
	assign digit_count = digit_count_q;
	assign checksum_ok = checksum_ok_q;

endmodule

// ===== rtl/core/cnlc_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cnlc_checker: port checks of the card number Luhn classifier
// Watches the command and result ports and flags results that break the
// sequencing or the class rules.
// ----------------------------------------------------------------------------
module cnlc_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           start,
	input logic                           busy,
	input logic                           done,
	input logic [cnlc_pkg::VERDICT_W-1:0] verdict,
	input logic [cnlc_pkg::COUNT_W-1:0]   digit_count,
	input logic                           checksum_ok
);

	// An accepted command makes the block busy in the next cycle.
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("block not busy after an accepted command");

	// A result transfer is only shown once the block is idle again.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result shown while busy");

	// No result in the cycle right after a command is accepted.
	a_no_early_done: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> !done)
		else $error("result right after an accepted command");

	// A class other than invalid needs a valid length and a passing check.
	a_class_rules: assert property (@(posedge clk) disable iff (!arst_n)
		(done && verdict != cnlc_pkg::VERDICT_INVALID) |->
		(checksum_ok && (digit_count == cnlc_pkg::LEN_13 ||
		digit_count == cnlc_pkg::LEN_15 || digit_count == cnlc_pkg::LEN_16)))
		else $error("class given to a number of wrong length or failed check");

	// The digit count never exceeds the largest possible length.
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (digit_count <= cnlc_pkg::COUNT_W'(cnlc_pkg::NUM_DIGITS)))
		else $error("digit count out of range");

endmodule

bind card_number_luhn_classifier cnlc_checker u_cnlc_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.start       (start),
	.busy        (busy),
	.done        (done),
	.verdict     (verdict),
	.digit_count (digit_count),
	.checksum_ok (checksum_ok)
);
